// ----- hdl/tvg_pkg.sv -----
package tvg_pkg;

	// field widths
	localparam int SEG_W   = 9;
	localparam int RAD_W   = 15;
	localparam int STRIP_W = 8;
	localparam int COL_W   = 9;
	localparam int POS_W   = 18;
	localparam int TEX_W   = 16;
	localparam int TRIG_W  = 18;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;

	// divide-by-reciprocal datapath: every numerator stays below 2**NUM_W
	// over the whole parameter range, denominators are at most 1024
	localparam int NUM_W = 25;
	localparam int REC_W = NUM_W - 2;
	localparam int DEN_W = 11;

	localparam int QUEUE_DEPTH = 8;

	localparam int MAX_SEGMENTS_DEF     = 256;
	localparam int SINE_TABLE_DEPTH_DEF = 256;
	localparam int SEG_MIN     = 3;
	localparam int SEG_REG_MAX = 511;

	localparam logic [TEX_W-1:0] TEX_MAX = 16'd32768;
	localparam logic signed [POS_W-1:0] POS_MAX = 18'sd131071;
	localparam logic signed [POS_W-1:0] POS_MIN = -18'sd131072;

	localparam logic [RAD_W-1:0] TUBE_RADIUS_RST   = 15'd1147;
	localparam logic [RAD_W-1:0] CENTER_RADIUS_RST = 15'd2458;
	localparam logic [SEG_W-1:0] SEGMENTS_RST      = 9'd16;

	localparam longint unsigned Q30_ONE     = 64'd1073741824;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TUBE_RADIUS,
		REG_CENTER_RADIUS,
		REG_RING_SEGMENTS,
		REG_TUBE_SEGMENTS
	} reg_idx_t;

	// segment counts already clamped to the legal range
	typedef struct packed {
		logic [RAD_W-1:0] tube_radius;
		logic [RAD_W-1:0] center_radius;
		logic [SEG_W-1:0] ring_seg;
		logic [SEG_W-1:0] tube_seg;
	} cfg_t;

	// floor(2**NUM_W / den) for den = 2*ring, 2*tube, 2*(tube+1)
	typedef struct packed {
		logic [REC_W-1:0] ring;
		logic [REC_W-1:0] tube;
		logic [REC_W-1:0] col;
	} rcp_t;

	typedef struct packed {
		logic [STRIP_W-1:0]       strip;
		logic signed [TRIG_W-1:0] cos_b;
		logic signed [TRIG_W-1:0] sin_b;
		logic [TEX_W-1:0]         tex_v;
	} item_t;

	// quarter-wave sine entry from a Q30 angle, odd polynomial in Horner form
	function automatic logic [16:0] sine_poly(input longint unsigned x);
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		x2 = (x * x) >> 30;
		t = Q30_ONE - x2 / 110;
		t = Q30_ONE - ((x2 * t) >> 30) / 72;
		t = Q30_ONE - ((x2 * t) >> 30) / 42;
		t = Q30_ONE - ((x2 * t) >> 30) / 20;
		t = Q30_ONE - ((x2 * t) >> 30) / 6;
		s = (x * t) >> 30;
		s = (s + 64'd16384) >> 15;
		if (s > 64'd32768)
			s = 64'd32768;
		return 17'(s);
	endfunction

	// shift right with rounding half away from zero
	function automatic logic signed [35:0] round_shr(input logic signed [35:0] v, input int s);
		logic [35:0] mag;
		logic [35:0] r;
		mag = v[35] ? 36'(-v) : 36'(v);
		r = (mag + (36'd1 << (s - 1))) >> s;
		return v[35] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [35:0] v);
		if (v > 36'sd131071)
			return POS_MAX;
		else if (v < -36'sd131072)
			return POS_MIN;
		else
			return v[POS_W-1:0];
	endfunction

endpackage

// ----- hdl/torus_vertex_generator.sv -----
// torus vertex generator: each (strip_index, column_index) beat yields two
// vertex beats, ring strip and ring strip+1, with doubled position in signed
// Q4.14, texture u/v in Q1.15 and last_vertex set on the second one. a front
// pipeline finds the column angle, its sine/cosine and v and drops the result
// into an 8-deep queue; the back pipeline pulls from the queue and runs one
// vertex per cycle while the output is not stalled, so the sustained input
// rate is set by the back pipeline issuing two vertices per queue entry.
// divisions by the segment counts use reciprocals made by a bit-serial
// divider: it runs after reset and after every register write, and in_ready
// stays low meanwhile
module torus_vertex_generator #(
	parameter int MAX_SEGMENTS     = tvg_pkg::MAX_SEGMENTS_DEF,
	parameter int SINE_TABLE_DEPTH = tvg_pkg::SINE_TABLE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_wr_en,
	input  logic [tvg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tvg_pkg::CFG_DATA_W-1:0]     cfg_data,
	// input beats
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [tvg_pkg::STRIP_W-1:0]        strip_index,
	input  logic [tvg_pkg::COL_W-1:0]          column_index,
	// vertex beats
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [tvg_pkg::POS_W-1:0]   pos_x,
	output logic signed [tvg_pkg::POS_W-1:0]   pos_y,
	output logic signed [tvg_pkg::POS_W-1:0]   pos_z,
	output logic [tvg_pkg::TEX_W-1:0]          tex_u,
	output logic [tvg_pkg::TEX_W-1:0]          tex_v,
	output logic                               last_vertex
);
	import tvg_pkg::*;

	// largest segment count the 9-bit registers can reach after clamping
	localparam int SEG_CAP = (MAX_SEGMENTS > SEG_REG_MAX) ? SEG_REG_MAX : MAX_SEGMENTS;

	logic [RAD_W-1:0] tube_radius_q, center_radius_q;
	logic [SEG_W-1:0] ring_segments_q, tube_segments_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tube_radius_q   <= TUBE_RADIUS_RST;
			center_radius_q <= CENTER_RADIUS_RST;
			ring_segments_q <= SEGMENTS_RST;
			tube_segments_q <= SEGMENTS_RST;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_TUBE_RADIUS:   tube_radius_q   <= cfg_data[RAD_W-1:0];
				REG_CENTER_RADIUS: center_radius_q <= cfg_data[RAD_W-1:0];
				REG_RING_SEGMENTS: ring_segments_q <= cfg_data[SEG_W-1:0];
				REG_TUBE_SEGMENTS: tube_segments_q <= cfg_data[SEG_W-1:0];
				default: ;
			endcase
		end
	end

	// out-of-range segment counts fold to the nearest legal value
	function automatic logic [SEG_W-1:0] clamp_seg(input logic [SEG_W-1:0] v);
		if (v < SEG_W'(SEG_MIN))
			return SEG_W'(SEG_MIN);
		else if (v > SEG_W'(SEG_CAP))
			return SEG_W'(SEG_CAP);
		else
			return v;
	endfunction

	cfg_t  cfg;
	rcp_t  rcp;
	logic  rcp_busy;
	logic  push, pop, empty;
	item_t push_item, head;

	always_comb begin
		cfg.tube_radius   = tube_radius_q;
		cfg.center_radius = center_radius_q;
		cfg.ring_seg      = clamp_seg(ring_segments_q);
		cfg.tube_seg      = clamp_seg(tube_segments_q);
	end

	// reciprocals of the segment counts, rebuilt after every write
	tvg_recip u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.start  (cfg_wr_en),
		.rcp    (rcp),
		.busy   (rcp_busy)
	);

	// column angle, its sine/cosine and texture v per input beat
	tvg_front #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.rcp          (rcp),
		.rcp_busy     (rcp_busy),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.strip_index  (strip_index),
		.column_index (column_index),
		.pop          (pop),
		.push         (push),
		.push_item    (push_item)
	);

	tvg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	// ring angle, radius and the two vertex beats per queue entry
	tvg_back #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.rcp         (rcp),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.tex_u       (tex_u),
		.tex_v       (tex_v),
		.last_vertex (last_vertex)
	);

	a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> !in_ready) else $error("input taken while reciprocals rebuild");

endmodule

// ----- hdl/tvg_sine.sv -----
module tvg_sine #(
	parameter int DEPTH = tvg_pkg::SINE_TABLE_DEPTH_DEF
) (
	input  logic [$clog2(4*DEPTH):0]          phase,
	output logic signed [tvg_pkg::TRIG_W-1:0] sin_v,
	output logic signed [tvg_pkg::TRIG_W-1:0] cos_v
);
	import tvg_pkg::*;

	localparam int PH_W  = $clog2(4*DEPTH);
	localparam int IDX_W = $clog2(DEPTH+1);
	localparam logic [PH_W:0] Q1 = (PH_W+1)'(DEPTH);
	localparam logic [PH_W:0] Q2 = (PH_W+1)'(2*DEPTH);
	localparam logic [PH_W:0] Q3 = (PH_W+1)'(3*DEPTH);
	localparam logic [PH_W:0] Q4 = (PH_W+1)'(4*DEPTH);

	logic [16:0] rom [DEPTH+1];

	for (genvar n = 0; n <= DEPTH; n++) begin : g_rom
		localparam longint unsigned X = (longint'(n) * HALF_PI_Q30 + DEPTH/2) / DEPTH;
		assign rom[n] = sine_poly(X);
	end

	// returns {negate, table index}
	function automatic logic [IDX_W:0] fold(input logic [PH_W:0] p);
		logic [PH_W:0] r;
		logic neg;
		if (p < Q1) begin
			r = p;
			neg = 1'b0;
		end else if (p < Q2) begin
			r = Q2 - p;
			neg = 1'b0;
		end else if (p < Q3) begin
			r = p - Q2;
			neg = 1'b1;
		end else begin
			r = Q4 - p;
			neg = 1'b1;
		end
		return {neg, r[IDX_W-1:0]};
	endfunction

	logic [PH_W:0] ps, pc0, pc;
	logic [IDX_W:0] fs, fc;
	logic signed [TRIG_W-1:0] vs, vc;

	always_comb begin
		ps  = (phase >= Q4) ? phase - Q4 : phase;
		pc0 = ps + Q1;
		pc  = (pc0 >= Q4) ? pc0 - Q4 : pc0;
		fs  = fold(ps);
		fc  = fold(pc);
		vs  = $signed(TRIG_W'(rom[fs[IDX_W-1:0]]));
		vc  = $signed(TRIG_W'(rom[fc[IDX_W-1:0]]));
		sin_v = fs[IDX_W] ? -vs : vs;
		cos_v = fc[IDX_W] ? -vc : vc;
	end

endmodule

// ----- hdl/tvg_recip.sv -----
module tvg_recip (
	input  logic          clk,
	input  logic          arst_n,
	input  tvg_pkg::cfg_t cfg,
	input  logic          start,
	output tvg_pkg::rcp_t rcp,
	output logic          busy
);
	import tvg_pkg::*;

	localparam int CNT_W = $clog2(NUM_W+1);

	typedef enum logic [1:0] {SEL_RING, SEL_TUBE, SEL_COL} sel_t;

	sel_t             sel_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W-1:0] rem_q;
	logic [REC_W-1:0] quo_q;
	rcp_t             rcp_q;

	logic [DEN_W-1:0] den;
	logic [DEN_W:0]   rem_sh, rem_sub;
	logic             take;
	logic [REC_W-1:0] quo_nx;

	always_comb begin
		case (sel_q)
			SEL_RING: den = DEN_W'({cfg.ring_seg, 1'b0});
			SEL_TUBE: den = DEN_W'({cfg.tube_seg, 1'b0});
			SEL_COL:  den = DEN_W'({cfg.tube_seg, 1'b0}) + DEN_W'(2);
			default:  den = DEN_W'({cfg.ring_seg, 1'b0});
		endcase
		// dividend is a one followed by NUM_W zeros
		rem_sh  = {rem_q, (cnt_q == CNT_W'(NUM_W))};
		take    = rem_sh >= {1'b0, den};
		rem_sub = rem_sh - {1'b0, den};
		quo_nx  = {quo_q[REC_W-2:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			sel_q  <= SEL_RING;
			cnt_q  <= CNT_W'(NUM_W);
			rem_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			sel_q  <= SEL_RING;
			cnt_q  <= CNT_W'(NUM_W);
			rem_q  <= '0;
		end else if (busy_q) begin
			quo_q <= quo_nx;
			if (cnt_q == '0) begin
				case (sel_q)
					SEL_RING: rcp_q.ring <= quo_nx;
					SEL_TUBE: rcp_q.tube <= quo_nx;
					default:  rcp_q.col  <= quo_nx;
				endcase
				rem_q <= '0;
				cnt_q <= CNT_W'(NUM_W);
				case (sel_q)
					SEL_RING: sel_q <= SEL_TUBE;
					SEL_TUBE: sel_q <= SEL_COL;
					default:  busy_q <= 1'b0;
				endcase
			end else begin
				rem_q <= take ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	assign rcp  = rcp_q;
	assign busy = busy_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q) else $error("reciprocal unit not busy after start");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> $past(sel_q) == SEL_COL)
		else $error("reciprocal unit finished before last value");

endmodule

// ----- hdl/tvg_queue.sv -----
module tvg_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tvg_pkg::item_t push_item,
	input  logic           pop,
	output tvg_pkg::item_t head,
	output logic           empty
);
	import tvg_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);

	item_t         mem [QUEUE_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + AW'(1);
			if (pop)
				rd_q <= rd_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	assign head  = mem[rd_q];
	assign empty = (cnt_q == '0);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> cnt_q != (AW+1)'(QUEUE_DEPTH)) else $error("push into full queue");

endmodule

// ----- hdl/tvg_front.sv -----
module tvg_front #(
	parameter int SINE_TABLE_DEPTH = tvg_pkg::SINE_TABLE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tvg_pkg::cfg_t                cfg,
	input  tvg_pkg::rcp_t                rcp,
	input  logic                         rcp_busy,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [tvg_pkg::STRIP_W-1:0]  strip_index,
	input  logic [tvg_pkg::COL_W-1:0]    column_index,
	input  logic                         pop,
	output logic                         push,
	output tvg_pkg::item_t               push_item
);
	import tvg_pkg::*;

	localparam int PH_W = $clog2(4*SINE_TABLE_DEPTH);
	localparam int AW   = $clog2(QUEUE_DEPTH);
	localparam int PJ_W = COL_W + 1 + REC_W;
	localparam int QJ_W = PJ_W - NUM_W;
	localparam int PW   = NUM_W + REC_W;

	logic [AW:0] credits_q;
	logic        accept;

	// credits cover items in this pipeline plus items in the queue
	assign in_ready = !rcp_busy && (credits_q < (AW+1)'(QUEUE_DEPTH));
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			credits_q <= '0;
		else
			credits_q <= credits_q + (AW+1)'(accept) - (AW+1)'(pop);
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [STRIP_W-1:0] i_s1, i_s2, i_s3, i_s4, i_s5;
	logic [COL_W-1:0]   j_s1, j_s2;
	logic [QJ_W-1:0]    qj_s2;
	logic [SEG_W-1:0]   t_s3;
	logic [NUM_W-1:0]   nc_s4, nv_s4;
	logic [REC_W-1:0]   qc_s4, qv_s4;
	logic [PH_W:0]      cph_s5;
	logic [TEX_W-1:0]   tv_s5;
	item_t              item_s6;

	logic [PJ_W-1:0]  pj;
	logic [17:0]      pt, dt, dt2;
	logic [SEG_W:0]   tc1;
	logic [SEG_W:0]   den_t;
	logic [NUM_W-1:0] nc, nv, rc, rv;
	logic [PW-1:0]    pc, pv;
	logic [REC_W-1:0] qc, qv;
	logic signed [TRIG_W-1:0] sb, cb;

	always_comb begin
		pj  = PJ_W'({j_s1, 1'b0}) * PJ_W'(rcp.col);
		tc1 = (SEG_W+1)'(cfg.tube_seg) + (SEG_W+1)'(1);
		pt  = 18'(qj_s2) * 18'(tc1);
		dt  = 18'(j_s2) - pt;
		dt2 = (dt >= 18'(tc1)) ? dt - 18'(tc1) : dt;
		// phase and texture v share the denominator 2*tube_seg
		den_t = {cfg.tube_seg, 1'b0};
		nc = NUM_W'(t_s3) * NUM_W'(8*SINE_TABLE_DEPTH) + NUM_W'(cfg.tube_seg);
		nv = NUM_W'({t_s3, 16'd0}) + NUM_W'(cfg.tube_seg);
		pc = PW'(nc) * PW'(rcp.tube);
		pv = PW'(nv) * PW'(rcp.tube);
		rc = nc_s4 - NUM_W'(PW'(qc_s4) * PW'(den_t));
		rv = nv_s4 - NUM_W'(PW'(qv_s4) * PW'(den_t));
		qc = (rc >= NUM_W'(den_t)) ? qc_s4 + REC_W'(1) : qc_s4;
		qv = (rv >= NUM_W'(den_t)) ? qv_s4 + REC_W'(1) : qv_s4;
	end

	tvg_sine #(.DEPTH(SINE_TABLE_DEPTH)) u_sine (
		.phase (cph_s5),
		.sin_v (sb),
		.cos_v (cb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			i_s1 <= strip_index;
			j_s1 <= column_index;
		end
		i_s2   <= i_s1;
		j_s2   <= j_s1;
		qj_s2  <= pj[PJ_W-1:NUM_W];
		i_s3   <= i_s2;
		t_s3   <= dt2[SEG_W-1:0];
		i_s4   <= i_s3;
		nc_s4  <= nc;
		nv_s4  <= nv;
		qc_s4  <= pc[PW-1:NUM_W];
		qv_s4  <= pv[PW-1:NUM_W];
		i_s5   <= i_s4;
		cph_s5 <= qc[PH_W:0];
		tv_s5  <= (qv > REC_W'(TEX_MAX)) ? TEX_MAX : qv[TEX_W-1:0];
		item_s6.strip <= i_s5;
		item_s6.cos_b <= cb;
		item_s6.sin_b <= sb;
		item_s6.tex_v <= tv_s5;
	end

	assign push      = v_s6;
	assign push_item = item_s6;

	a_credits: assert property (@(posedge clk) disable iff (!arst_n)
		credits_q <= (AW+1)'(QUEUE_DEPTH)) else $error("credit count past queue depth");

endmodule

// ----- hdl/tvg_back.sv -----
module tvg_back #(
	parameter int SINE_TABLE_DEPTH = tvg_pkg::SINE_TABLE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tvg_pkg::cfg_t                    cfg,
	input  tvg_pkg::rcp_t                    rcp,
	input  tvg_pkg::item_t                   head,
	input  logic                             empty,
	output logic                             pop,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [tvg_pkg::POS_W-1:0] pos_x,
	output logic signed [tvg_pkg::POS_W-1:0] pos_y,
	output logic signed [tvg_pkg::POS_W-1:0] pos_z,
	output logic [tvg_pkg::TEX_W-1:0]        tex_u,
	output logic [tvg_pkg::TEX_W-1:0]        tex_v,
	output logic                             last_vertex
);
	import tvg_pkg::*;

	localparam int PH_W = $clog2(4*SINE_TABLE_DEPTH);
	localparam int PM_W = SEG_W + 1 + REC_W;
	localparam int QM_W = PM_W - NUM_W;
	localparam int PW   = NUM_W + REC_W;

	logic adv, k_q, issue;

	assign adv   = !out_valid || out_ready;
	assign issue = adv && !empty;
	assign pop   = issue && k_q;

	logic v_b1, v_b2, v_b3, v_b4, v_b5, v_b6, v_b7, v_b8;
	item_t e_b1, e_b2, e_b3, e_b4, e_b5, e_b6, e_b7;
	logic k_b1, k_b2, k_b3, k_b4, k_b5, k_b6, k_b7;
	logic [SEG_W-1:0] n_b2, m_b3;
	logic [QM_W-1:0]  qm_b2;
	logic [NUM_W-1:0] nu_b2, na_b4;
	logic [REC_W-1:0] qu_b2, qa_b4;
	logic [TEX_W-1:0] u_b3, u_b4, u_b5, u_b6, u_b7;
	logic [PH_W:0]    aph_b5;
	logic signed [TRIG_W-1:0] sa_b6, ca_b6;
	logic signed [POS_W-1:0]  rad_b7, pz_b7;

	logic [SEG_W-1:0] n;
	logic [PM_W-1:0]  pm;
	logic [NUM_W-1:0] nu, ru, na, ra;
	logic [PW-1:0]    pu, pa;
	logic [17:0]      dm, dm2;
	logic [SEG_W:0]   den_r;
	logic [REC_W-1:0] qu, qa;
	logic signed [TRIG_W-1:0] sa, ca;
	logic signed [35:0] pca, psa, rad_w, pxp, pyp;

	always_comb begin
		// strip plus ring offset, and its quotient by ring_seg
		n     = SEG_W'(e_b1.strip) + SEG_W'(k_b1);
		pm    = PM_W'({n, 1'b0}) * PM_W'(rcp.ring);
		nu    = NUM_W'({n, 16'd0}) + NUM_W'(cfg.ring_seg);
		pu    = PW'(nu) * PW'(rcp.ring);
		den_r = {cfg.ring_seg, 1'b0};
		dm    = 18'(n_b2) - 18'(qm_b2) * 18'(cfg.ring_seg);
		dm2   = (dm >= 18'(cfg.ring_seg)) ? dm - 18'(cfg.ring_seg) : dm;
		ru    = nu_b2 - NUM_W'(PW'(qu_b2) * PW'(den_r));
		qu    = (ru >= NUM_W'(den_r)) ? qu_b2 + REC_W'(1) : qu_b2;
		// ring phase at the middle of the strip
		na    = NUM_W'({m_b3, 1'b1}) * NUM_W'(4*SINE_TABLE_DEPTH) + NUM_W'(cfg.ring_seg);
		pa    = PW'(na) * PW'(rcp.ring);
		ra    = na_b4 - NUM_W'(PW'(qa_b4) * PW'(den_r));
		qa    = (ra >= NUM_W'(den_r)) ? qa_b4 + REC_W'(1) : qa_b4;
		// ring radius, then position
		pca   = 36'($signed({1'b0, cfg.tube_radius})) * 36'(ca_b6);
		psa   = 36'($signed({1'b0, cfg.tube_radius})) * 36'(sa_b6);
		rad_w = round_shr(pca, 15) + $signed({21'd0, cfg.center_radius});
		pxp   = 36'(rad_b7) * 36'(e_b7.cos_b);
		pyp   = 36'(rad_b7) * 36'(e_b7.sin_b);
	end

	tvg_sine #(.DEPTH(SINE_TABLE_DEPTH)) u_sine (
		.phase (aph_b5),
		.sin_v (sa),
		.cos_v (ca)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q  <= 1'b0;
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			v_b3 <= 1'b0;
			v_b4 <= 1'b0;
			v_b5 <= 1'b0;
			v_b6 <= 1'b0;
			v_b7 <= 1'b0;
			v_b8 <= 1'b0;
		end else if (adv) begin
			if (issue)
				k_q <= !k_q;
			v_b1 <= issue;
			v_b2 <= v_b1;
			v_b3 <= v_b2;
			v_b4 <= v_b3;
			v_b5 <= v_b4;
			v_b6 <= v_b5;
			v_b7 <= v_b6;
			v_b8 <= v_b7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			e_b1  <= head;
			k_b1  <= k_q;
			e_b2  <= e_b1;
			k_b2  <= k_b1;
			n_b2  <= n;
			qm_b2 <= pm[PM_W-1:NUM_W];
			nu_b2 <= nu;
			qu_b2 <= pu[PW-1:NUM_W];
			e_b3  <= e_b2;
			k_b3  <= k_b2;
			m_b3  <= dm2[SEG_W-1:0];
			u_b3  <= (qu > REC_W'(TEX_MAX)) ? TEX_MAX : qu[TEX_W-1:0];
			e_b4  <= e_b3;
			k_b4  <= k_b3;
			u_b4  <= u_b3;
			na_b4 <= na;
			qa_b4 <= pa[PW-1:NUM_W];
			e_b5  <= e_b4;
			k_b5  <= k_b4;
			u_b5  <= u_b4;
			aph_b5 <= qa[PH_W:0];
			e_b6  <= e_b5;
			k_b6  <= k_b5;
			u_b6  <= u_b5;
			sa_b6 <= sa;
			ca_b6 <= ca;
			e_b7  <= e_b6;
			k_b7  <= k_b6;
			u_b7  <= u_b6;
			rad_b7 <= rad_w[POS_W-1:0];
			pz_b7 <= sat_pos(round_shr(psa, 14));
			pos_x <= sat_pos(round_shr(pxp, 14));
			pos_y <= sat_pos(round_shr(pyp, 14));
			pos_z <= pz_b7;
			tex_u <= u_b7;
			tex_v <= e_b7.tex_v;
			last_vertex <= k_b7;
		end
	end

	assign out_valid = v_b8;

	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_vertex |=> out_valid && last_vertex)
		else $error("second vertex of pair does not follow the first");

endmodule
